### sv/msbs_pkg.sv
// Package: shared types, codes and defaults of the masked byte signature scanner.
package msbs_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int RANGE_BITS_DEF  = 7;

  localparam int PATTERN_W   = 128;
  localparam int MASK_W      = 16;
  localparam int LEN_W       = 5;
  localparam int LIMIT_W     = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  localparam int RANGE_W  = 7;
  localparam int OFFSET_W = 32;
  localparam int COUNT_W  = 16;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXACT_MASK   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLLECT_MODE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_LIMIT  = 3'd5;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_MISSING   = 2'd0,
    ST_UNIQUE    = 2'd1,
    ST_AMBIGUOUS = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       range_end;
    logic       scan_end;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [1:0]          status;
    logic [RANGE_W-1:0]  range_number;
    logic [OFFSET_W-1:0] match_offset;
    logic [COUNT_W-1:0]  match_count;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  typedef struct packed {
    logic pattern_ok;
    logic hit;
  } win_stat_t;

endpackage

### sv/masked_byte_signature_scanner_unit.sv
// Top level of the masked byte signature scanner.
//
//   channel | direction | handshake          | payload
//   in      | into      | in_valid/in_ready  | in_item   (data_byte, range_end, scan_end)
//   out     | out of    | out_valid/out_ready| out_item  (kind, status, range, offset, count, last)
//   cfg     | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Unless input stalls, one byte is accepted per cycle; the window compare is a single
// registered pass. A collect-mode match on the last byte of a scan gives two items,
// which the result queue drains one per cycle while out_ready is high. Input stalls
// while reset is high or the 8-entry result queue is close to full.
// Reset is synchronous, clears scan state and config registers, and sets the match limit to one.
module masked_byte_signature_scanner_unit
  import msbs_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int RANGE_BITS  = RANGE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [MASK_W-1:0]     exact_mask;
  logic [LEN_W-1:0]      pattern_length;
  logic                  collect_mode;
  logic [LIMIT_W-1:0]    match_limit;

  logic     s1_valid;
  in_item_t s1;

  logic [OFFSET_BITS-1:0] range_position;
  logic [RANGE_BITS-1:0]  range_counter;
  status_t                scan_status;
  logic [RANGE_BITS-1:0]  found_range;
  logic [OFFSET_BITS-1:0] found_offset;
  logic [COUNT_W-1:0]     collected;

  status_t                scan_status_next;
  logic [RANGE_BITS-1:0]  found_range_next;
  logic [OFFSET_BITS-1:0] found_offset_next;
  logic [COUNT_W-1:0]     collected_next;

  win_ctrl_t              wctrl;
  win_stat_t              wstat;
  logic [OFFSET_BITS-1:0] start;
  logic                   collect_hit;
  logic                   resolve_hit;
  out_item_t              match_item;
  out_item_t              summary_item;
  logic                   wr_en0;
  logic                   wr_en1;
  out_item_t              wr_data0;
  logic [FIFO_CNT_W-1:0]  fifo_count;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      exact_mask     <= '0;
      pattern_length <= '0;
      collect_mode   <= 1'b0;
      match_limit    <= LIMIT_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PATTERN_LOW:  pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH: pattern_high   <= cfg_data;
        CFG_EXACT_MASK:   exact_mask     <= MASK_W'(cfg_data);
        CFG_PATTERN_LEN:  pattern_length <= LEN_W'(cfg_data);
        CFG_COLLECT_MODE: collect_mode   <= cfg_data[0];
        CFG_MATCH_LIMIT:  match_limit    <= LIMIT_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // room for this item's results and the next one's
  assign in_ready = !rst && (s1_valid ? (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 4))
                                      : (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_item;
    end
  end

  assign wctrl = '{shift: s1_valid, clear: s1.range_end || s1.scan_end};

  msbs_window #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (wctrl),
    .data_byte      (s1.data_byte),
    .pattern_bytes  ({pattern_high, pattern_low}),
    .exact_mask     (exact_mask),
    .pattern_length (pattern_length),
    .stat           (wstat)
  );

  assign start = range_position + OFFSET_BITS'(1) - OFFSET_BITS'(pattern_length);
  assign collect_hit = s1_valid && wstat.hit && collect_mode && (collected < match_limit);
  assign resolve_hit = s1_valid && wstat.hit && !collect_mode;

  always_comb begin
    scan_status_next  = scan_status;
    found_range_next  = found_range;
    found_offset_next = found_offset;
    collected_next    = collect_hit ? collected + COUNT_W'(1) : collected;
    if (resolve_hit) begin
      if (scan_status == ST_MISSING) begin
        scan_status_next  = ST_UNIQUE;
        found_range_next  = range_counter;
        found_offset_next = start;
      end else begin
        scan_status_next  = ST_AMBIGUOUS;
        found_range_next  = '0;
        found_offset_next = '0;
      end
    end
  end

  always_comb begin
    match_item.kind         = KIND_MATCH;
    match_item.status       = ST_UNIQUE;
    match_item.range_number = RANGE_W'(range_counter);
    match_item.match_offset = OFFSET_W'(start);
    match_item.match_count  = collected_next;
    match_item.last         = !s1.scan_end;

    summary_item.kind         = KIND_SUMMARY;
    summary_item.status       = ST_MISSING;
    summary_item.range_number = '0;
    summary_item.match_offset = '0;
    summary_item.match_count  = '0;
    summary_item.last         = 1'b1;
    if (!wstat.pattern_ok) begin
      summary_item.status = ST_INVALID;
    end else if (collect_mode) begin
      summary_item.status      = (collected_next != '0) ? ST_UNIQUE : ST_MISSING;
      summary_item.match_count = collected_next;
    end else begin
      summary_item.status = scan_status_next;
      if (scan_status_next == ST_UNIQUE) begin
        summary_item.range_number = RANGE_W'(found_range_next);
        summary_item.match_offset = OFFSET_W'(found_offset_next);
      end
    end
  end

  assign wr_en0   = collect_hit || (s1_valid && s1.scan_end);
  assign wr_en1   = collect_hit && s1.scan_end;
  assign wr_data0 = collect_hit ? match_item : summary_item;

  msbs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en0    (wr_en0),
    .wr_en1    (wr_en1),
    .wr_data0  (wr_data0),
    .wr_data1  (summary_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .count     (fifo_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      range_position <= '0;
      range_counter  <= '0;
      scan_status    <= ST_MISSING;
      found_range    <= '0;
      found_offset   <= '0;
      collected      <= '0;
    end else if (s1_valid) begin
      if (s1.scan_end) begin
        range_position <= '0;
        range_counter  <= '0;
        scan_status    <= ST_MISSING;
        found_range    <= '0;
        found_offset   <= '0;
        collected      <= '0;
      end else begin
        scan_status  <= scan_status_next;
        found_range  <= found_range_next;
        found_offset <= found_offset_next;
        collected    <= collected_next;
        if (s1.range_end) begin
          range_position <= '0;
          range_counter  <= range_counter + RANGE_BITS'(1);
        end else begin
          range_position <= range_position + OFFSET_BITS'(1);
        end
      end
    end
  end

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
    else $error("result queue lacks room for an item in flight");

  a_scan_cleared: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.scan_end) |=> (range_counter == '0 && collected == '0 &&
                                   scan_status == ST_MISSING))
    else $error("scan state not cleared after summary");

  a_ambiguous_final: assert property (@(posedge clk) disable iff (rst)
    (scan_status == ST_AMBIGUOUS && !(s1_valid && s1.scan_end)) |=>
    (scan_status == ST_AMBIGUOUS))
    else $error("ambiguous status left before end of scan");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (wr_en0 && wr_data0.kind == KIND_SUMMARY) |-> (wr_data0.last && !wr_en1))
    else $error("summary not marked last");

endmodule

### sv/msbs_window.sv
// Byte window of the current range and parallel masked pattern compare.
module msbs_window
  import msbs_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  win_ctrl_t            ctrl,
  input  logic [7:0]           data_byte,
  input  logic [PATTERN_W-1:0] pattern_bytes,
  input  logic [MASK_W-1:0]    exact_mask,
  input  logic [LEN_W-1:0]     pattern_length,
  output win_stat_t            stat
);

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  logic [7:0]        win [PATTERN_MAX];
  logic [7:0]        win_next [PATTERN_MAX];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              mismatch;
  logic              pattern_ok;
  logic [MASK_W-1:0] used;

  always_comb begin
    win_next[0] = data_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_next[k] = win[k-1];
    end
    fill_next = (fill < FILL_W'(PATTERN_MAX)) ? fill + FILL_W'(1) : fill;
  end

  always_comb begin
    for (int k = 0; k < MASK_W; k++) begin
      used[k] = (k < int'(pattern_length));
    end
    pattern_ok = (pattern_length != '0) && (int'(pattern_length) <= PATTERN_MAX) &&
                 ((exact_mask & used) != '0);
  end

  // pattern byte i lines up with window slot len-1-i
  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (exact_mask[i] && (i + j + 1 == int'(pattern_length)) &&
            (pattern_bytes[8*i +: 8] != win_next[j])) begin
          mismatch = 1'b1;
        end
      end
    end
  end

  assign stat = '{pattern_ok: pattern_ok,
                  hit: pattern_ok && (LEN_W'(fill_next) >= pattern_length) && !mismatch};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        win[k] <= '0;
      end
    end else if (ctrl.shift) begin
      if (ctrl.clear) begin
        fill <= '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
          win[k] <= '0;
        end
      end else begin
        fill <= fill_next;
        win  <= win_next;
      end
    end
  end

endmodule

### sv/msbs_out_fifo.sv
// Result queue: takes up to two items a cycle, hands out one while out_ready is high.
module msbs_out_fifo
  import msbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en0,
  input  logic                  wr_en1,
  input  out_item_t             wr_data0,
  input  out_item_t             wr_data1,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  output logic [FIFO_CNT_W-1:0] count
);

  out_item_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;
  logic [FIFO_CNT_W-1:0] n_push;

  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign n_push    = FIFO_CNT_W'(wr_en0) + FIFO_CNT_W'(wr_en1);

  always_ff @(posedge clk) begin
    if (wr_en0) begin
      mem[wr_ptr] <= wr_data0;
    end
    if (wr_en1) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + n_push - FIFO_CNT_W'(pop);
    end
  end

endmodule

### test/testbench.sv
// Testbench: self-checking scoreboard for the masked byte signature scanner.
`timescale 1ns / 1ps

module testbench;
  import msbs_pkg::*;

  typedef struct packed {
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
  } reg_wr_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  in_item_t  byte_q[$];
  reg_wr_t   reg_q[$];
  out_item_t result_q[$];

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_rx = 1'b0;
  int   fail_count = 0;
  int   queued = 0;

  // scanner copy: registers
  logic [63:0] pat_lo, pat_hi;
  logic [15:0] exact_bits;
  logic [4:0]  pat_len;
  logic        collect_on;
  logic [15:0] limit_val;
  // scanner copy: scan state
  logic [7:0]  win_bytes[16];
  logic [4:0]  win_fill;
  logic [31:0] range_pos;
  logic [6:0]  range_idx;
  status_t     scan_state;
  logic [6:0]  found_rng;
  logic [31:0] found_off;
  logic [15:0] emitted;

  masked_byte_signature_scanner_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_range();
    for (int i = 0; i < 16; i++) win_bytes[i] = 8'h00;
    win_fill  = '0;
    range_pos = '0;
  endfunction

  function automatic void clear_scan();
    clear_range();
    range_idx  = '0;
    scan_state = ST_MISSING;
    found_rng  = '0;
    found_off  = '0;
    emitted    = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_PATTERN_LOW:  pat_lo = val;
      CFG_PATTERN_HIGH: pat_hi = val;
      CFG_EXACT_MASK:   exact_bits = val[15:0];
      CFG_PATTERN_LEN:  pat_len = val[4:0];
      CFG_COLLECT_MODE: collect_on = val[0];
      CFG_MATCH_LIMIT:  limit_val = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic out_item_t mk_result(logic kind, status_t st, logic [6:0] rng,
                                          logic [31:0] off, logic [15:0] cnt);
    out_item_t r;
    r.kind         = kind;
    r.status       = st;
    r.range_number = rng;
    r.match_offset = off;
    r.match_count  = cnt;
    r.last         = 1'b0;
    return r;
  endfunction

  // advance the window by one byte and queue what the scanner should emit
  task automatic scan_byte(in_item_t it);
    logic [31:0]  used;
    logic [127:0] pw;
    logic         ok;
    logic         hit;
    logic [31:0]  start;
    out_item_t    made[2];
    int           n;
    pw   = {pat_hi, pat_lo};
    used = (32'd1 << pat_len) - 32'd1;
    ok   = (pat_len != 5'd0) && (pat_len <= 5'd16) && ((exact_bits & used[15:0]) != 16'd0);
    for (int i = 15; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = it.data_byte;
    if (win_fill < 5'd16) win_fill = win_fill + 5'd1;
    hit = ok && (win_fill >= pat_len);
    if (hit) begin
      for (int i = 0; i < int'(pat_len); i++) begin
        if (exact_bits[i] && pw[8*i +: 8] != win_bytes[int'(pat_len) - 1 - i]) hit = 1'b0;
      end
    end
    n = 0;
    start = range_pos - 32'(pat_len) + 32'd1;
    if (hit) begin
      if (collect_on) begin
        if (emitted < limit_val) begin
          emitted = emitted + 16'd1;
          made[n] = mk_result(KIND_MATCH, ST_UNIQUE, range_idx, start, emitted);
          n++;
        end
      end else if (scan_state == ST_MISSING) begin
        scan_state = ST_UNIQUE;
        found_rng  = range_idx;
        found_off  = start;
      end else begin
        scan_state = ST_AMBIGUOUS;
        found_rng  = '0;
        found_off  = '0;
      end
    end
    range_pos = range_pos + 32'd1;
    if (it.scan_end) begin
      if (!ok)
        made[n] = mk_result(KIND_SUMMARY, ST_INVALID, '0, '0, '0);
      else if (collect_on)
        made[n] = mk_result(KIND_SUMMARY, (emitted != 0) ? ST_UNIQUE : ST_MISSING,
                            '0, '0, emitted);
      else if (scan_state == ST_UNIQUE)
        made[n] = mk_result(KIND_SUMMARY, ST_UNIQUE, found_rng, found_off, '0);
      else
        made[n] = mk_result(KIND_SUMMARY, scan_state, '0, '0, '0);
      n++;
      clear_scan();
    end else if (it.range_end) begin
      clear_range();
      range_idx = range_idx + 7'd1;
    end
    for (int j = 0; j < n; j++) begin
      if (j == n - 1) made[j].last = 1'b1;
      result_q.push_back(made[j]);
    end
  endtask

  function automatic bit field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    bit        bad;
    if (result_q.size() == 0) begin
      $display("%0t unexpected result: expected none, actual %h", $time, got);
      fail_count++;
    end else begin
      want = result_q.pop_front();
      bad  = 1'b0;
      bad |= field_diff("kind", 32'(want.kind), 32'(got.kind));
      bad |= field_diff("status", 32'(want.status), 32'(got.status));
      bad |= field_diff("range_number", 32'(want.range_number), 32'(got.range_number));
      bad |= field_diff("match_offset", want.match_offset, got.match_offset);
      bad |= field_diff("match_count", 32'(want.match_count), 32'(got.match_count));
      bad |= field_diff("last", 32'(want.last), 32'(got.last));
      if (bad) fail_count++;
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) scan_byte(in_item);
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item  <= byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (!cfg_valid || cfg_ready) begin
        if (reg_q.size() != 0) begin
          {cfg_index, cfg_data} <= reg_q.pop_front();
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_item);
      out_ready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic push_item(logic [7:0] b, logic re, logic se);
    in_item_t it;
    it.data_byte = b;
    it.range_end = re;
    it.scan_end  = se;
    byte_q.push_back(it);
    queued++;
  endtask

  task automatic settle();
    while (byte_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [63:0] noisy(logic [63:0] val, logic [63:0] keep);
    return ({$urandom, $urandom} & ~keep) | (val & keep);
  endfunction

  task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, logic [15:0] m,
                              logic [4:0] len, logic col, logic [15:0] lim);
    reg_q.push_back('{CFG_PATTERN_LOW, lo});
    reg_q.push_back('{CFG_PATTERN_HIGH, hi});
    reg_q.push_back('{CFG_EXACT_MASK, noisy(64'(m), 64'hFFFF)});
    reg_q.push_back('{CFG_PATTERN_LEN, noisy(64'(len), 64'h1F)});
    reg_q.push_back('{CFG_COLLECT_MODE, noisy(64'(col), 64'h1)});
    reg_q.push_back('{CFG_MATCH_LIMIT, noisy(64'(lim), 64'hFFFF)});
    while (reg_q.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  task automatic random_pattern();
    int          sel;
    logic [4:0]  len;
    logic [15:0] m;
    logic [15:0] lim;
    logic [63:0] lo;
    logic [63:0] hi;
    sel = $urandom_range(0, 19);
    if (sel == 0) len = 5'd0;
    else if (sel == 1) len = 5'($urandom_range(17, 31));
    else if (sel < 5) len = 5'd16;
    else len = 5'($urandom_range(1, 8));
    m = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 5) == 0) m = 16'hFFFF;
    if ($urandom_range(0, 15) == 0) m = 16'h0000;
    case ($urandom_range(0, 4))
      0: lim = 16'd0;
      1: lim = 16'd1;
      2: lim = 16'hFFFF;
      3: lim = 16'($urandom_range(2, 5));
      default: lim = 16'($urandom_range(0, 65535));
    endcase
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      lo = '0;
      hi = '0;
    end else if (sel == 1) begin
      lo = '1;
      hi = '1;
    end
    load_pattern(lo, hi, m, len, 1'($urandom_range(0, 1)), lim);
  endtask

  // ranges of mixed noise, often with the pattern planted, sometimes cut or spoilt
  task automatic add_scan(int nranges, int max_len);
    logic [7:0]   rbytes[$];
    logic [127:0] pw;
    int           rlen;
    int           off;
    logic         re;
    pw = {pat_hi, pat_lo};
    for (int r = 0; r < nranges; r++) begin
      rbytes.delete();
      rlen = $urandom_range(1, max_len);
      for (int i = 0; i < rlen; i++) begin
        case ($urandom_range(0, 6))
          0, 1, 2: rbytes.push_back(8'($urandom_range(0, 255)));
          3, 4:    rbytes.push_back(pw[8*$urandom_range(0, 15) +: 8]);
          5:       rbytes.push_back(8'h00);
          default: rbytes.push_back(8'hFF);
        endcase
      end
      if (pat_len >= 5'd1 && pat_len <= 5'd16 && $urandom_range(0, 99) < 70) begin
        if (int'(pat_len) <= rlen && $urandom_range(0, 2) != 0)
          off = $urandom_range(0, rlen - int'(pat_len));
        else
          off = $urandom_range(0, rlen - 1);
        for (int i = 0; i < int'(pat_len) && off + i < rlen; i++) begin
          if (exact_bits[i]) rbytes[off+i] = pw[8*i +: 8];
        end
        if ($urandom_range(0, 9) == 0) rbytes[off] = ~rbytes[off];
      end
      for (int i = 0; i < rlen; i++) begin
        re = 1'b0;
        if (i == rlen - 1) re = (r < nranges - 1) ? 1'b1 : 1'($urandom_range(0, 1));
        push_item(rbytes[i], re, (r == nranges - 1) && (i == rlen - 1));
      end
    end
  endtask

  initial begin
    int first;
    pat_lo     = '0;
    pat_hi     = '0;
    exact_bits = '0;
    pat_len    = '0;
    collect_on = 1'b0;
    limit_val  = 16'd1;
    clear_scan();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset pattern is invalid
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1);
    settle();
    // unique match, then one cut by a range end
    load_pattern(64'h0000_0000_00FF_C35A, '1, 16'h0025, 5'd3, 1'b0, 16'd1);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'h77, 1'b1, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    settle();
    // ambiguous
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'h11, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'h22, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    settle();
    // collect, second match on the scan's last byte
    load_pattern(64'h0000_0000_00FF_C35A, '1, 16'h0025, 5'd3, 1'b1, 16'd2);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    settle();
    // collect with zero limit
    load_pattern(64'h0000_0000_00FF_C35A, '0, 16'h0025, 5'd3, 1'b1, 16'd0);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    settle();
    // length beyond the window, and no exact byte in use
    load_pattern('1, '1, 16'hFFFF, 5'd31, 1'b0, 16'hFFFF);
    push_item(8'h5A, 1'b0, 1'b1);
    settle();
    load_pattern('1, '1, 16'hFFF8, 5'd3, 1'b1, 16'hFFFF);
    push_item(8'hFF, 1'b1, 1'b1);
    settle();

    // many one-byte ranges so the range number wraps
    load_pattern(64'h0000_0000_0000_00A5, '0, 16'h0001, 5'd1, 1'b1, 16'hFFFF);
    for (int i = 0; i < 140; i++)
      push_item(($urandom_range(0, 9) < 3) ? 8'hA5 : 8'($urandom_range(0, 255)),
                1'b1, i == 139);
    settle();

    // receiver holds off while most bytes match: queue fills, input stalls
    load_pattern('0, '0, 16'h0001, 5'd1, 1'b1, 16'hFFFF);
    hold_rx <= 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    for (int i = 0; i < 60; i++)
      push_item((i % 7 == 3) ? 8'h11 : 8'h00, i % 20 == 19, i == 59);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      for (int k = 0; k < 3; k++) begin
        random_pattern();
        first = queued;
        while (queued - first < 12)
          add_scan($urandom_range(1, 4), (pat_len > 5'd8) ? 40 : 14);
        settle();
      end
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### masked_byte_signature_scanner_unit.f
sv/msbs_pkg.sv
sv/msbs_window.sv
sv/msbs_out_fifo.sv
sv/masked_byte_signature_scanner_unit.sv
test/testbench.sv
